// File: src/cor_pkg.sv
// Shared types and constants for the circle outline rasterizer.
`default_nettype none

package cor_pkg;

    // Seed of the error term: e starts at ERR_BASE - 2r.
    localparam int ERR_BASE = 2;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // latch a new request and seed the walk
        logic step;   // register the current points and advance the walk
    } t_cor_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic done;   // the step taken now is the final one of the circle
    } t_cor_sts;

endpackage

`default_nettype wire

// File: src/cor_datapath.sv
// Datapath of the circle outline rasterizer: walk registers and point outputs.
`default_nettype none

module cor_datapath
    import cor_pkg::*;
#(
    parameter int MAX_RADIUS = 31,
    parameter int COORD_BITS = 12
) (
    input  wire                           i_clk,
    input  t_cor_cmd                      i_cmd,
    output t_cor_sts                      o_sts,
    input  wire signed [COORD_BITS-1:0]   i_center_x,
    input  wire signed [COORD_BITS-1:0]   i_center_y,
    input  wire        [4:0]              i_radius,
    output logic signed [COORD_BITS:0]    o_p0_x,
    output logic signed [COORD_BITS:0]    o_p0_y,
    output logic signed [COORD_BITS:0]    o_p1_x,
    output logic signed [COORD_BITS:0]    o_p1_y,
    output logic signed [COORD_BITS:0]    o_p2_x,
    output logic signed [COORD_BITS:0]    o_p2_y,
    output logic signed [COORD_BITS:0]    o_p3_x,
    output logic signed [COORD_BITS:0]    o_p3_y,
    output logic                          o_last
);

    localparam int RW = $clog2(MAX_RADIUS + 2) + 1;          // walk x / y width
    localparam int EW = RW + 3;                                // error term width
    localparam int OB = COORD_BITS + 1;                        // point width
    localparam int SW = ((COORD_BITS > RW) ? COORD_BITS : RW) + 1;

    logic signed [COORD_BITS-1:0] r_xc, r_yc;
    logic signed [RW-1:0]         r_x, r_y;
    logic signed [EW-1:0]         r_e;

    logic signed [RW-1:0]         sat_r;
    logic signed [RW-1:0]         y1, x1;
    logic signed [EW-1:0]         e1, e2;
    logic                         inc_y, inc_x;
    logic signed [SW-1:0]         xc_w, yc_w, x_w, y_w;

    // Clamp the radius to the supported maximum.
    always_comb begin
        if (int'(i_radius) > MAX_RADIUS) begin
            sat_r = RW'(MAX_RADIUS);
        end else begin
            sat_r = RW'(i_radius);
        end
    end

    // One iteration of the error-term walk.
    always_comb begin
        inc_y = (r_e <= EW'(r_y));
        y1    = inc_y ? (r_y + RW'(1)) : r_y;
        e1    = inc_y ? (r_e + (EW'(y1) <<< 1) + EW'(1)) : r_e;
        inc_x = (r_e > EW'(r_x)) || (e1 > EW'(y1));
        x1    = inc_x ? (r_x + RW'(1)) : r_x;
        e2    = inc_x ? (e1 + (EW'(x1) <<< 1) + EW'(1)) : e1;
    end

    assign o_sts.done = ~x1[RW-1];

    assign xc_w = SW'(r_xc);
    assign yc_w = SW'(r_yc);
    assign x_w  = SW'(r_x);
    assign y_w  = SW'(r_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xc <= i_center_x;
            r_yc <= i_center_y;
            r_x  <= -sat_r;
            r_y  <= '0;
            r_e  <= EW'(ERR_BASE) - (EW'(sat_r) <<< 1);
        end else if (i_cmd.step) begin
            r_x <= x1;
            r_y <= y1;
            r_e <= e2;
        end
        if (i_cmd.step) begin
            o_p0_x <= OB'(xc_w + x_w);
            o_p0_y <= OB'(yc_w - y_w);
            o_p1_x <= OB'(xc_w - x_w);
            o_p1_y <= OB'(yc_w + y_w);
            o_p2_x <= OB'(xc_w + y_w);
            o_p2_y <= OB'(yc_w + x_w);
            o_p3_x <= OB'(xc_w - y_w);
            o_p3_y <= OB'(yc_w - x_w);
            o_last <= ~x1[RW-1];
        end
    end

endmodule

`default_nettype wire

// File: src/cor_ctrl.sv
// Controller of the circle outline rasterizer: request handshake and walk sequencing.
`default_nettype none

module cor_ctrl
    import cor_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_cor_cmd  o_cmd,
    input  t_cor_sts  i_sts
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Load in idle; in the walk, step when the output register is free or draining.
    assign o_cmd.load = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.step = (r_state == ST_WALK) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (o_cmd.step && i_sts.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: src/circle_outline_rasterizer.sv
// Top level of the circle outline rasterizer.
//
// Input channel (i_in_valid / o_in_ready): one request is a circle command,
// a signed centre (i_center_x, i_center_y) and a radius (i_radius). Radii
// above MAX_RADIUS are clamped to MAX_RADIUS.
// Output channel (o_out_valid / i_out_ready): one result per iteration of the
// error-term walk, carrying the four symmetric points p0..p3 as signed,
// unclipped coordinates one bit wider than the centre; o_last marks the final
// result of a circle. A circle of radius r gives at most 2r results, or one
// result when r is zero.
// First result: taking the request loads the walk registers; the next step
// then registers the first result into the output register.
// Throughput: one result per cycle while the receiver keeps up. The single
// walk register set in the datapath sets this rate: the next request is taken
// once the final result is in the output register, even while it still waits.
// Stall: while a result waits and i_out_ready is low, the output register
// holds it and the walk does not advance.
// Reset: synchronous, active low; returns to idle with no result pending.
`default_nettype none

module circle_outline_rasterizer
    import cor_pkg::*;
#(
    parameter int MAX_RADIUS = 31,
    parameter int COORD_BITS = 12
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire signed [COORD_BITS-1:0] i_center_x,
    input  wire signed [COORD_BITS-1:0] i_center_y,
    input  wire        [4:0]            i_radius,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic signed [COORD_BITS:0]  o_p0_x,
    output logic signed [COORD_BITS:0]  o_p0_y,
    output logic signed [COORD_BITS:0]  o_p1_x,
    output logic signed [COORD_BITS:0]  o_p1_y,
    output logic signed [COORD_BITS:0]  o_p2_x,
    output logic signed [COORD_BITS:0]  o_p2_y,
    output logic signed [COORD_BITS:0]  o_p3_x,
    output logic signed [COORD_BITS:0]  o_p3_y,
    output logic                        o_last
);

    t_cor_cmd cmd;
    t_cor_sts sts;

    // Handshakes and sequencing.
    cor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Walk registers, point arithmetic and output register.
    cor_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_p0_x     (o_p0_x),
        .o_p0_y     (o_p0_y),
        .o_p1_x     (o_p1_x),
        .o_p1_y     (o_p1_y),
        .o_p2_x     (o_p2_x),
        .o_p2_y     (o_p2_y),
        .o_p3_x     (o_p3_x),
        .o_p3_y     (o_p3_y),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire
